[src/isl_pkg.sv]
package isl_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int ID_W       = 32;

    // Output field widths
    localparam int SLOT_OUT_W = 6;
    localparam int CNT_OUT_W  = 7;

    // Command codes
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } t_cmd;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

endpackage

[src/isl_ram.sv]
module isl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/id_slot_table_top.sv]
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-------------------------------------------
// command   | in        | start, busy        | i_command, i_ident, i_batch_end
// result    | out       | o_done (strobe)    | o_success, o_slot_index, o_live_count,
//           |           |                    | o_batch_end_out
//
// A transaction with identifier zero or an unused command code answers on the next cycle.
// Otherwise the sequencer reads the slot memory one slot per cycle through a single compare
// unit and stops at the first match; the result strobes in the cycle after the hit, and busy
// is high throughout the scan. Reset (i_rst_n low, synchronous) clears the per-slot occupied
// bits and the live count, so no clearing pass is needed. The receiver cannot stall: o_done
// is a one-cycle strobe.
module id_slot_table_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_command,
    input  logic [isl_pkg::ID_W-1:0]        i_ident,
    input  logic                            i_batch_end,
    output logic                            o_done,
    output logic                            o_success,
    output logic [isl_pkg::SLOT_OUT_W-1:0]  o_slot_index,
    output logic [isl_pkg::CNT_OUT_W-1:0]   o_live_count,
    output logic                            o_batch_end_out
);

    localparam int SW = isl_pkg::SLOT_W;
    localparam int CW = isl_pkg::CNT_W;
    localparam int IW = isl_pkg::ID_W;
    localparam int NS = isl_pkg::SLOT_COUNT;

    isl_pkg::t_state r_state, n_state;
    logic [NS-1:0]   r_valid, n_valid;
    logic [CW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_addr, n_addr;
    logic            r_issue, n_issue;
    logic            r_cmp_vld, n_cmp_vld;
    logic [SW-1:0]   r_cmp_addr, n_cmp_addr;
    logic            r_valid_q;
    logic [1:0]      r_cmd, n_cmd;
    logic [IW-1:0]   r_ident, n_ident;
    logic            r_mark, n_mark;
    logic            r_done, n_done;
    logic            r_success, n_success;
    logic [SW-1:0]   r_slot, n_slot;

    logic            ram_we;
    logic [IW-1:0]   ram_rdata;
    logic            cmd_ok;
    logic            is_add;
    logic            scan_hit;
    logic            scan_last;
    logic [SW+isl_pkg::SLOT_OUT_W-1:0] slot_ext;
    logic [CW+isl_pkg::CNT_OUT_W-1:0]  count_ext;

    // Slot memory: written on a successful add, read once per scan cycle
    isl_ram #(
        .WIDTH (IW),
        .DEPTH (NS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cmp_addr),
        .i_wdata (r_ident),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Decode the command and the compare result of the slot read last cycle
    assign cmd_ok = (i_command == isl_pkg::CMD_ADD) || (i_command == isl_pkg::CMD_REMOVE) ||
                    (i_command == isl_pkg::CMD_FIND);
    assign is_add = (r_cmd == isl_pkg::CMD_ADD);
    assign scan_hit = r_cmp_vld && (is_add ? !r_valid_q : (r_valid_q && (ram_rdata == r_ident)));
    assign scan_last = r_cmp_vld && (r_cmp_addr == SW'(NS - 1));

    // Sequence the scan and update the table on a hit
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_count    = r_count;
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_cmp_vld  = 1'b0;
        n_cmp_addr = r_addr;
        n_cmd      = r_cmd;
        n_ident    = r_ident;
        n_mark     = r_mark;
        n_done     = 1'b0;
        n_success  = r_success;
        n_slot     = r_slot;
        ram_we     = 1'b0;
        case (r_state)
            isl_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_command;
                    n_ident = i_ident;
                    n_mark  = i_batch_end;
                    if ((i_ident != '0) && cmd_ok) begin
                        n_state = isl_pkg::ST_SCAN;
                        n_addr  = '0;
                        n_issue = 1'b1;
                    end else begin
                        n_done    = 1'b1;
                        n_success = 1'b0;
                        n_slot    = '0;
                    end
                end
            end
            isl_pkg::ST_SCAN: begin
                // Issue the next slot read
                if (r_issue) begin
                    n_cmp_vld  = 1'b1;
                    n_cmp_addr = r_addr;
                    n_addr     = r_addr + SW'(1);
                    if (r_addr == SW'(NS - 1)) begin
                        n_issue = 1'b0;
                    end
                end
                // Finish on the first match or after the last slot
                if (scan_hit) begin
                    n_state   = isl_pkg::ST_IDLE;
                    n_issue   = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_done    = 1'b1;
                    n_success = 1'b1;
                    n_slot    = r_cmp_addr;
                    if (is_add) begin
                        ram_we              = 1'b1;
                        n_valid[r_cmp_addr] = 1'b1;
                        if (r_count < CW'(NS)) begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_cmd == isl_pkg::CMD_REMOVE) begin
                        n_valid[r_cmp_addr] = 1'b0;
                        if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end else if (scan_last) begin
                    n_state   = isl_pkg::ST_IDLE;
                    n_issue   = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_done    = 1'b1;
                    n_success = 1'b0;
                    n_slot    = '0;
                end
            end
            default: begin
                n_state = isl_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= isl_pkg::ST_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_issue   <= n_issue;
            r_cmp_vld <= n_cmp_vld;
            r_done    <= n_done;
        end
    end

    // Hold payload and scan pointers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_cmp_addr <= n_cmp_addr;
        r_valid_q  <= r_valid[r_addr];
        r_cmd      <= n_cmd;
        r_ident    <= n_ident;
        r_mark     <= n_mark;
        r_success  <= n_success;
        r_slot     <= n_slot;
    end

    // Drive the result ports, trimmed to the field widths
    assign slot_ext        = {{isl_pkg::SLOT_OUT_W{1'b0}}, r_slot};
    assign count_ext       = {{isl_pkg::CNT_OUT_W{1'b0}}, r_count};
    assign busy            = (r_state == isl_pkg::ST_SCAN);
    assign o_done          = r_done;
    assign o_success       = r_success;
    assign o_slot_index    = slot_ext[isl_pkg::SLOT_OUT_W-1:0];
    assign o_live_count    = count_ext[isl_pkg::CNT_OUT_W-1:0];
    assign o_batch_end_out = r_mark;

    // Live count always matches the number of occupied slots
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("live count differs from occupied slots");

    // A result strobe follows either a scan or an immediate reject
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state == isl_pkg::ST_SCAN) || $past(start && !busy)))
        else $error("result strobe without a transaction");

    // A scan hit produces a successful result on the next cycle
    a_hit_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isl_pkg::ST_SCAN) && scan_hit |=> o_done && o_success)
        else $error("scan hit not reported");

    // A successful add leaves the reported slot occupied
    a_add_occupies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isl_pkg::ST_SCAN) && scan_hit && is_add |=> r_valid[$past(r_cmp_addr)])
        else $error("added slot not marked occupied");

endmodule

[tb/id_slot_table_top_test.sv]
`timescale 1ns / 1ps

module id_slot_table_top_test;

    // Command code outside the enum; the block answers it without touching the table
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET  = 550;
    localparam int DIR_ROWS     = 21;
    localparam int POOL_SIZE    = 16;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 80;
    localparam int CALM_TAIL    = 60;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_traffic_mode;

    typedef struct packed {
        logic                           success;
        logic [isl_pkg::SLOT_OUT_W-1:0] slot;
        logic [isl_pkg::CNT_OUT_W-1:0]  count;
        logic                           mark;
    } t_table_result;

    typedef struct packed {
        logic [1:0]                     cmd;
        logic [isl_pkg::ID_W-1:0]       ident;
        logic                           mark;
        logic                           typed;
        logic                           success;
        logic [isl_pkg::SLOT_OUT_W-1:0] slot;
        logic [isl_pkg::CNT_OUT_W-1:0]  count;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [1:0]                     i_command = isl_pkg::CMD_ADD;
    logic [isl_pkg::ID_W-1:0]       i_ident = '0;
    logic                           i_batch_end = 1'b0;
    logic                           o_done;
    logic                           o_success;
    logic [isl_pkg::SLOT_OUT_W-1:0] o_slot_index;
    logic [isl_pkg::CNT_OUT_W-1:0]  o_live_count;
    logic                           o_batch_end_out;

    // Typed expectation riding along with the transaction on the command ports
    logic          typed_valid = 1'b0;
    t_table_result typed_result = '0;

    // Mirror of the slot table
    logic [isl_pkg::ID_W-1:0] slot_mirror [isl_pkg::SLOT_COUNT];
    int unsigned              live_mirror;

    t_table_result            table_answers [$];
    logic [isl_pkg::ID_W-1:0] id_pool [POOL_SIZE];
    t_stim_row                directed_rows [DIR_ROWS];
    int                       item_count = 0;
    int                       mismatches = 0;
    int                       stall_cycles = 0;

    id_slot_table_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_ident         (i_ident),
        .i_batch_end     (i_batch_end),
        .o_done          (o_done),
        .o_success       (o_success),
        .o_slot_index    (o_slot_index),
        .o_live_count    (o_live_count),
        .o_batch_end_out (o_batch_end_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one transaction to the mirror and return the answer it should give
    function automatic t_table_result apply_to_mirror(logic [1:0] cmd,
                                                      logic [isl_pkg::ID_W-1:0] ident,
                                                      logic mark);
        t_table_result            res;
        int                       hit;
        logic [isl_pkg::ID_W-1:0] target;
        hit = -1;
        target = (cmd == isl_pkg::CMD_ADD) ? '0 : ident;
        if (ident != '0 && cmd != CMD_UNUSED) begin
            for (int i = 0; i < isl_pkg::SLOT_COUNT; i++) begin
                if (hit < 0 && slot_mirror[i] == target) hit = i;
            end
            if (hit >= 0 && cmd == isl_pkg::CMD_ADD) begin
                slot_mirror[hit] = ident;
                if (live_mirror < isl_pkg::SLOT_COUNT) live_mirror++;
            end else if (hit >= 0 && cmd == isl_pkg::CMD_REMOVE) begin
                slot_mirror[hit] = '0;
                if (live_mirror > 0) live_mirror--;
            end
        end
        res.success = (hit >= 0);
        res.slot    = (hit >= 0) ? hit[isl_pkg::SLOT_OUT_W-1:0] : '0;
        res.count   = live_mirror[isl_pkg::CNT_OUT_W-1:0];
        res.mark    = mark;
        return res;
    endfunction

    function automatic logic [1:0] pick_command(t_traffic_mode mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return CMD_UNUSED;
        case (mode)
            MODE_FILL: begin
                if (r < 93) return isl_pkg::CMD_ADD;
                if (r < 97) return isl_pkg::CMD_FIND;
                return isl_pkg::CMD_REMOVE;
            end
            MODE_DRAIN: begin
                if (r < 15) return isl_pkg::CMD_ADD;
                if (r < 85) return isl_pkg::CMD_REMOVE;
                return isl_pkg::CMD_FIND;
            end
            default: begin
                if (r < 40) return isl_pkg::CMD_ADD;
                if (r < 70) return isl_pkg::CMD_REMOVE;
                return isl_pkg::CMD_FIND;
            end
        endcase
    endfunction

    // Mostly identifiers that are or were in the table, some raw values and zero
    function automatic logic [isl_pkg::ID_W-1:0] pick_ident(logic [1:0] cmd);
        int          r;
        int unsigned s;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 14) return $urandom;
        if (r < 50 && cmd != isl_pkg::CMD_ADD) begin
            s = $urandom_range(0, isl_pkg::SLOT_COUNT - 1);
            if (slot_mirror[s] != '0) return slot_mirror[s];
        end
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Hold the transaction on the ports until the block takes it
    task automatic send_item(logic [1:0] cmd, logic [isl_pkg::ID_W-1:0] ident, logic mark,
                             logic typed, t_table_result typed_res);
        @(negedge i_clk);
        start        <= 1'b1;
        i_command    <= cmd;
        i_ident      <= ident;
        i_batch_end  <= mark;
        typed_valid  <= typed;
        typed_result <= typed_res;
        do @(posedge i_clk); while (busy);
        item_count++;
    endtask

    // Drop start for a while; optionally hold off until every answer is back
    task automatic pause_sender(int cycles, bit drain);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
        if (drain) begin
            while (table_answers.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic maybe_gap(bit gaps_on);
        if (gaps_on && $urandom_range(0, 99) < 30) pause_sender($urandom_range(1, 4), 1'b0);
    endtask

    // Predict on acceptance, check on strobe, watch for a hang
    always @(posedge i_clk) begin
        t_table_result want;
        t_table_result got;
        if (i_rst_n) begin
            stall_cycles++;
            if (start && !busy) begin
                want = apply_to_mirror(i_command, i_ident, i_batch_end);
                if (typed_valid) want = typed_result;
                table_answers.push_back(want);
                stall_cycles = 0;
            end
            if (o_done) begin
                stall_cycles = 0;
                got = '{o_success, o_slot_index, o_live_count, o_batch_end_out};
                if (table_answers.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected none, actual %0h",
                             $time, got);
                end else begin
                    want = table_answers.pop_front();
                    report_field("success", 32'(want.success), 32'(got.success));
                    report_field("slot_index", 32'(want.slot), 32'(got.slot));
                    report_field("live_count", 32'(want.count), 32'(got.count));
                    report_field("batch_end_out", 32'(want.mark), 32'(got.mark));
                end
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("id_slot_table_top test failed");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row     row;
        t_traffic_mode mode;
        int            burst;
        bit            gaps_on;
        logic [1:0]    cmd;

        for (int i = 0; i < isl_pkg::SLOT_COUNT; i++) slot_mirror[i] = '0;
        live_mirror = 0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = $urandom;
            if (id_pool[i] == '0) id_pool[i] = 32'h1;
        end

        // cmd, ident, mark, typed, success, slot, count
        directed_rows = '{
            '{isl_pkg::CMD_FIND,   32'h0000_0001, 1'b0, 1'b1, 1'b0, 6'd0, 7'd0},
            '{isl_pkg::CMD_ADD,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 6'd0, 7'd0},
            '{isl_pkg::CMD_ADD,    32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd0, 7'd1},
            '{isl_pkg::CMD_ADD,    32'h0000_0001, 1'b1, 1'b1, 1'b1, 6'd1, 7'd2},
            '{isl_pkg::CMD_ADD,    32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd2, 7'd3},
            '{isl_pkg::CMD_FIND,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 6'd0, 7'd3},
            '{isl_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd0, 7'd2},
            '{isl_pkg::CMD_FIND,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 6'd2, 7'd2},
            '{CMD_UNUSED,          32'h0000_0005, 1'b0, 1'b1, 1'b0, 6'd0, 7'd2},
            '{CMD_UNUSED,          32'h0000_0000, 1'b1, 1'b1, 1'b0, 6'd0, 7'd2},
            '{isl_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 6'd0, 7'd2},
            '{isl_pkg::CMD_FIND,   32'h0000_0000, 1'b1, 1'b1, 1'b0, 6'd0, 7'd2},
            '{isl_pkg::CMD_REMOVE, 32'h1234_5678, 1'b0, 1'b1, 1'b0, 6'd0, 7'd2},
            '{isl_pkg::CMD_ADD,    32'hAAAA_AAAA, 1'b1, 1'b1, 1'b1, 6'd0, 7'd3},
            '{isl_pkg::CMD_ADD,    32'h5555_5555, 1'b0, 1'b1, 1'b1, 6'd3, 7'd4},
            '{isl_pkg::CMD_FIND,   32'h5555_5555, 1'b1, 1'b1, 1'b1, 6'd3, 7'd4},
            '{isl_pkg::CMD_FIND,   32'h0000_0001, 1'b0, 1'b1, 1'b1, 6'd1, 7'd4},
            '{isl_pkg::CMD_REMOVE, 32'h0000_0001, 1'b1, 1'b1, 1'b1, 6'd1, 7'd3},
            '{isl_pkg::CMD_REMOVE, 32'h0000_0001, 1'b0, 1'b1, 1'b0, 6'd0, 7'd3},
            '{CMD_UNUSED,          32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd0, 7'd3},
            '{isl_pkg::CMD_ADD,    32'h8000_0000, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0}
        };

        // Hold reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.cmd, row.ident, row.mark, row.typed,
                      '{row.success, row.slot, row.count, row.mark});
            maybe_gap(1'b1);
        end

        // Fill past full, let it settle, then drain it
        for (int i = 0; i < 90; i++) begin
            cmd = pick_command(MODE_FILL);
            send_item(cmd, pick_ident(cmd), 1'($urandom_range(0, 1)), 1'b0, '0);
            maybe_gap(1'b1);
        end
        pause_sender(1, 1'b1);
        for (int i = 0; i < 90; i++) begin
            cmd = pick_command(MODE_DRAIN);
            send_item(cmd, pick_ident(cmd), 1'($urandom_range(0, 1)), 1'b0, '0);
            maybe_gap(1'b0);
        end
        pause_sender(1, 1'b1);

        // Random bursts of mixed traffic; no gaps near the end
        while (item_count < ITEM_TARGET) begin
            mode    = t_traffic_mode'($urandom_range(0, 2));
            burst   = $urandom_range(20, 60);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < burst && item_count < ITEM_TARGET; i++) begin
                cmd = pick_command(mode);
                send_item(cmd, pick_ident(cmd), 1'($urandom_range(0, 1)), 1'b0, '0);
                maybe_gap(gaps_on && item_count < ITEM_TARGET - CALM_TAIL);
            end
        end

        // Wait out the last answers
        pause_sender(0, 1'b1);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("id_slot_table_top test passed");
        end else begin
            $display("id_slot_table_top test failed");
        end
        $finish;
    end

endmodule
